/* hw/rtl/slvo_pkg.sv */
// shared types and constants for the smallest-last vertex ordering block
package slvo_pkg;

   localparam int RP_DEPTH = 257;
   localparam int NB_DEPTH = 4096;
   localparam int VX_DEPTH = 256;
   localparam int STK_DEPTH = VX_DEPTH * VX_DEPTH;

   localparam logic [8:0]  VCOUNT_MAX = 9'd256;
   localparam logic [12:0] NB_LIMIT   = 13'd4096;
   localparam logic [12:0] DEG_SAT    = 13'd255;

   localparam logic [1:0] REQ_ROW_PTR  = 2'd0;
   localparam logic [1:0] REQ_NEIGHBOR = 2'd1;
   localparam logic [1:0] REQ_START    = 2'd2;
   localparam logic [1:0] REQ_READ     = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_I_RP0, ST_I_RP1, ST_I_ROW, ST_I_CNT, ST_I_PUSH,
      ST_M_CNT0, ST_M_SEL, ST_Z_RD, ST_Z_PLACE, ST_S_RD, ST_S_CHK,
      ST_P_POP, ST_P_PLACE, ST_P_RP0, ST_P_RP1, ST_P_ROW,
      ST_N_RD, ST_N_CHK, ST_N_DEG, ST_N_POP, ST_N_SWAP, ST_N_PUSH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_IDLE, OP_RD_RP_U, OP_RD_RP_U1, OP_ROW, OP_INIT_RD_CNT,
      OP_INIT_PUSH, OP_RD_CNT0, OP_FINISH, OP_ZERO_BEGIN, OP_SEARCH_BEGIN,
      OP_ZERO_RD, OP_ZERO_CLR, OP_ZERO_PLACE, OP_SEARCH_RD, OP_SEARCH_NEXT,
      OP_TOP, OP_POP, OP_PLACE, OP_NB_RD, OP_NB_END, OP_NB_CHK, OP_NB_DEG,
      OP_NB_POP, OP_NB_SWAP, OP_NB_PUSH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic u_end;
      logic pos_zero;
      logic cnt_nz;
      logic z_more;
      logic d_end;
      logic k_end;
      logic v_out;
      logic skip;
   } stat_type;

endpackage

/* hw/rtl/slvo_ctrl.sv */
// sequencer for load, read and the ordering walk
module slvo_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_type,
   input  slvo_pkg::stat_type stat,
   output slvo_pkg::cmd_type  cmd,
   output logic              busy
);
   import slvo_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.op = OP_IDLE;
            if (start && req_type == REQ_START) state_in = ST_I_RP0;
         end
         ST_I_RP0: begin
            if (stat.u_end) begin
               state_in = ST_M_CNT0;
            end else begin
               cmd.op = OP_RD_RP_U;
               state_in = ST_I_RP1;
            end
         end
         ST_I_RP1: begin
            cmd.op = OP_RD_RP_U1;
            state_in = ST_I_ROW;
         end
         ST_I_ROW: begin
            cmd.op = OP_ROW;
            state_in = ST_I_CNT;
         end
         ST_I_CNT: begin
            cmd.op = OP_INIT_RD_CNT;
            state_in = ST_I_PUSH;
         end
         ST_I_PUSH: begin
            cmd.op = OP_INIT_PUSH;
            state_in = ST_I_RP0;
         end
         ST_M_CNT0: begin
            if (stat.pos_zero) begin
               cmd.op = OP_FINISH;
               state_in = ST_IDLE;
            end else begin
               cmd.op = OP_RD_CNT0;
               state_in = ST_M_SEL;
            end
         end
         ST_M_SEL: begin
            if (stat.cnt_nz) begin
               cmd.op = OP_ZERO_BEGIN;
               state_in = ST_Z_RD;
            end else begin
               cmd.op = OP_SEARCH_BEGIN;
               state_in = ST_S_RD;
            end
         end
         ST_Z_RD: begin
            if (stat.z_more) begin
               cmd.op = OP_ZERO_RD;
               state_in = ST_Z_PLACE;
            end else begin
               cmd.op = OP_ZERO_CLR;
               state_in = ST_M_CNT0;
            end
         end
         ST_Z_PLACE: begin
            cmd.op = OP_ZERO_PLACE;
            state_in = ST_Z_RD;
         end
         ST_S_RD: begin
            if (stat.d_end) begin
               cmd.op = OP_FINISH;
               state_in = ST_IDLE;
            end else begin
               cmd.op = OP_SEARCH_RD;
               state_in = ST_S_CHK;
            end
         end
         ST_S_CHK: begin
            if (stat.cnt_nz) begin
               cmd.op = OP_TOP;
               state_in = ST_P_POP;
            end else begin
               cmd.op = OP_SEARCH_NEXT;
               state_in = ST_S_RD;
            end
         end
         ST_P_POP: begin
            cmd.op = OP_POP;
            state_in = ST_P_PLACE;
         end
         ST_P_PLACE: begin
            cmd.op = OP_PLACE;
            state_in = ST_P_RP0;
         end
         ST_P_RP0: begin
            cmd.op = OP_RD_RP_U;
            state_in = ST_P_RP1;
         end
         ST_P_RP1: begin
            cmd.op = OP_RD_RP_U1;
            state_in = ST_P_ROW;
         end
         ST_P_ROW: begin
            cmd.op = OP_ROW;
            state_in = ST_N_RD;
         end
         ST_N_RD: begin
            if (stat.k_end) begin
               cmd.op = OP_NB_END;
               state_in = ST_M_CNT0;
            end else begin
               cmd.op = OP_NB_RD;
               state_in = ST_N_CHK;
            end
         end
         ST_N_CHK: begin
            cmd.op = OP_NB_CHK;
            state_in = stat.v_out ? ST_N_RD : ST_N_DEG;
         end
         ST_N_DEG: begin
            if (stat.skip) begin
               state_in = ST_N_RD;
            end else begin
               cmd.op = OP_NB_DEG;
               state_in = ST_N_POP;
            end
         end
         ST_N_POP: begin
            cmd.op = OP_NB_POP;
            state_in = ST_N_SWAP;
         end
         ST_N_SWAP: begin
            cmd.op = OP_NB_SWAP;
            state_in = ST_N_PUSH;
         end
         ST_N_PUSH: begin
            cmd.op = OP_NB_PUSH;
            state_in = ST_N_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/slvo_dpath.sv */
// graph tables, degree stacks, ordered list and working registers
module slvo_dpath (
   input  logic               clock,
   input  logic               reset,
   input  slvo_pkg::cmd_type  cmd,
   output slvo_pkg::stat_type stat,
   input  logic               start,
   input  logic [1:0]         req_type,
   input  logic [11:0]        req_address,
   input  logic [12:0]        req_value,
   input  logic               csr_wr_en,
   input  logic [8:0]         csr_wr_data,
   output logic               rsp_valid,
   output logic [7:0]         rsp_ordered_vertex,
   output logic               rsp_read_error
);
   import slvo_pkg::*;

   // memories
   logic [12:0] rp_mem   [0:RP_DEPTH-1];
   logic [12:0] nb_mem   [0:NB_DEPTH-1];
   logic [7:0]  deg_mem  [0:VX_DEPTH-1];
   logic        mark_mem [0:VX_DEPTH-1];
   logic [7:0]  slot_mem [0:VX_DEPTH-1];
   logic [7:0]  stk_mem  [0:STK_DEPTH-1];
   logic [8:0]  cnt_mem  [0:VX_DEPTH-1];
   logic [7:0]  ord_mem  [0:VX_DEPTH-1];
   logic [VX_DEPTH-1:0] cnt_vld_ff, cnt_vld_in;

   logic [12:0] rp_rd_ff, nb_rd_ff;
   logic [7:0]  deg_rd_ff, slot_rd_ff, stk_rd_ff, ord_rd_ff;
   logic        mark_rd_ff, cnt_rdv_ff;
   logic [8:0]  cnt_rd_ff;

   logic        rp_we, nb_we, deg_we, mark_we, slot_we, stk_we, cnt_we, ord_we;
   logic [8:0]  rp_waddr, rp_raddr;
   logic [11:0] nb_waddr, nb_raddr;
   logic [7:0]  deg_waddr, mark_waddr, slot_waddr, cnt_waddr, ord_waddr;
   logic [7:0]  vx_raddr, cnt_raddr, ord_raddr;
   logic [15:0] stk_waddr, stk_raddr;
   logic [12:0] rp_wdata, nb_wdata;
   logic [7:0]  deg_wdata, slot_wdata, stk_wdata, ord_wdata;
   logic        mark_wdata;
   logic [8:0]  cnt_wdata;

   // working registers
   logic [8:0]  n_ff, n_in, u_ff, u_in, pos_ff, pos_in, d_ff, d_in, lb_ff, lb_in;
   logic [8:0]  i_ff, i_in, cnt0_ff, cnt0_in;
   logic [7:0]  top_ff, top_in, v_ff, v_in, vd_ff, vd_in, s_ff, s_in;
   logic [12:0] lo_ff, lo_in, hi_ff, hi_in;
   logic        done_ff, done_in, rsp_valid_ff, rsp_valid_in, err_ff, err_in;

   logic [8:0]  cnt_val, cnt_dec, pos_dec;
   logic [12:0] row_hi, row_lo, row_len;
   logic [7:0]  row_deg;

   assign cnt_val = cnt_rdv_ff ? cnt_rd_ff : 9'd0;
   assign cnt_dec = cnt_val - 9'd1;
   assign pos_dec = pos_ff - 9'd1;
   assign row_hi  = (rp_rd_ff > NB_LIMIT) ? NB_LIMIT : rp_rd_ff;
   assign row_lo  = (lo_ff > row_hi) ? row_hi : lo_ff;
   assign row_len = hi_ff - lo_ff;
   assign row_deg = (row_len > DEG_SAT) ? DEG_SAT[7:0] : row_len[7:0];

   always_comb begin
      rp_we = 1'b0;  rp_waddr = '0;  rp_wdata = '0;  rp_raddr = '0;
      nb_we = 1'b0;  nb_waddr = '0;  nb_wdata = '0;  nb_raddr = '0;
      deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0;
      mark_we = 1'b0; mark_waddr = '0; mark_wdata = 1'b0;
      slot_we = 1'b0; slot_waddr = '0; slot_wdata = '0;
      vx_raddr = '0;
      stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
      cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
      ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
      cnt_vld_in = cnt_vld_ff;
      n_in = n_ff; u_in = u_ff; pos_in = pos_ff; d_in = d_ff; lb_in = lb_ff;
      i_in = i_ff; cnt0_in = cnt0_ff; top_in = top_ff; v_in = v_ff;
      vd_in = vd_ff; s_in = s_ff; lo_in = lo_ff; hi_in = hi_ff;
      done_in = done_ff; rsp_valid_in = 1'b0; err_in = err_ff;

      case (cmd.op)
         OP_IDLE: begin
            if (start) begin
               case (req_type)
                  REQ_ROW_PTR: begin
                     if (req_address <= 12'(VCOUNT_MAX)) begin
                        rp_we = 1'b1;
                        rp_waddr = req_address[8:0];
                        rp_wdata = req_value;
                        done_in = 1'b0;
                     end
                  end
                  REQ_NEIGHBOR: begin
                     nb_we = 1'b1;
                     nb_waddr = req_address;
                     nb_wdata = req_value;
                     done_in = 1'b0;
                  end
                  REQ_START: begin
                     cnt_vld_in = '0;
                     u_in = '0;
                     pos_in = n_ff;
                     lb_in = 9'd1;
                     done_in = 1'b0;
                  end
                  REQ_READ: begin
                     ord_raddr = req_address[7:0];
                     rsp_valid_in = 1'b1;
                     err_in = !done_ff || (req_address >= {3'b000, n_ff});
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         OP_RD_RP_U: rp_raddr = u_ff;
         OP_RD_RP_U1: begin
            lo_in = rp_rd_ff;
            rp_raddr = u_ff + 9'd1;
         end
         OP_ROW: begin
            hi_in = row_hi;
            lo_in = row_lo;
         end
         OP_INIT_RD_CNT: begin
            d_in = {1'b0, row_deg};
            cnt_raddr = row_deg;
         end
         OP_INIT_PUSH: begin
            slot_we = 1'b1; slot_waddr = u_ff[7:0]; slot_wdata = cnt_val[7:0];
            stk_we = 1'b1; stk_waddr = {d_ff[7:0], cnt_val[7:0]}; stk_wdata = u_ff[7:0];
            cnt_we = 1'b1; cnt_waddr = d_ff[7:0]; cnt_wdata = cnt_val + 9'd1;
            deg_we = 1'b1; deg_waddr = u_ff[7:0]; deg_wdata = d_ff[7:0];
            mark_we = 1'b1; mark_waddr = u_ff[7:0]; mark_wdata = 1'b0;
            u_in = u_ff + 9'd1;
         end
         OP_RD_CNT0: cnt_raddr = '0;
         OP_FINISH: done_in = 1'b1;
         OP_ZERO_BEGIN: begin
            i_in = '0;
            cnt0_in = cnt_val;
         end
         OP_SEARCH_BEGIN: d_in = lb_ff;
         OP_ZERO_RD: stk_raddr = {8'd0, i_ff[7:0]};
         OP_ZERO_CLR: begin
            cnt_we = 1'b1; cnt_waddr = '0; cnt_wdata = '0;
         end
         OP_ZERO_PLACE: begin
            ord_we = 1'b1; ord_waddr = pos_dec[7:0]; ord_wdata = stk_rd_ff;
            mark_we = 1'b1; mark_waddr = stk_rd_ff; mark_wdata = 1'b1;
            pos_in = pos_dec;
            i_in = i_ff + 9'd1;
         end
         OP_SEARCH_RD: cnt_raddr = d_ff[7:0];
         OP_SEARCH_NEXT: d_in = d_ff + 9'd1;
         OP_TOP: top_in = cnt_dec[7:0];
         OP_POP: begin
            cnt_we = 1'b1; cnt_waddr = d_ff[7:0]; cnt_wdata = {1'b0, top_ff};
            stk_raddr = {d_ff[7:0], top_ff};
         end
         OP_PLACE: begin
            u_in = {1'b0, stk_rd_ff};
            ord_we = 1'b1; ord_waddr = pos_dec[7:0]; ord_wdata = stk_rd_ff;
            mark_we = 1'b1; mark_waddr = stk_rd_ff; mark_wdata = 1'b1;
            pos_in = pos_dec;
         end
         OP_NB_RD: nb_raddr = lo_ff[11:0];
         // neighbors fell at most one stack, so nothing lies below d-1
         OP_NB_END: lb_in = (d_ff > 9'd1) ? d_ff - 9'd1 : 9'd1;
         OP_NB_CHK: begin
            v_in = nb_rd_ff[7:0];
            lo_in = lo_ff + 13'd1;
            vx_raddr = nb_rd_ff[7:0];
         end
         OP_NB_DEG: begin
            vd_in = deg_rd_ff;
            s_in = slot_rd_ff;
            cnt_raddr = deg_rd_ff;
         end
         OP_NB_POP: begin
            cnt_we = 1'b1; cnt_waddr = vd_ff; cnt_wdata = cnt_dec;
            stk_raddr = {vd_ff, cnt_dec[7:0]};
         end
         OP_NB_SWAP: begin
            // move the old top into the hole left by the neighbor
            stk_we = 1'b1; stk_waddr = {vd_ff, s_ff}; stk_wdata = stk_rd_ff;
            slot_we = 1'b1; slot_waddr = stk_rd_ff; slot_wdata = s_ff;
            deg_we = 1'b1; deg_waddr = v_ff; deg_wdata = vd_ff - 8'd1;
            cnt_raddr = vd_ff - 8'd1;
         end
         OP_NB_PUSH: begin
            slot_we = 1'b1; slot_waddr = v_ff; slot_wdata = cnt_val[7:0];
            stk_we = 1'b1; stk_waddr = {vd_ff - 8'd1, cnt_val[7:0]}; stk_wdata = v_ff;
            cnt_we = 1'b1; cnt_waddr = vd_ff - 8'd1; cnt_wdata = cnt_val + 9'd1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      if (cnt_we) cnt_vld_in[cnt_waddr] = 1'b1;

      if (csr_wr_en) begin
         n_in = (csr_wr_data > VCOUNT_MAX) ? VCOUNT_MAX : csr_wr_data;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rp_we) rp_mem[rp_waddr] <= rp_wdata;
      rp_rd_ff <= rp_mem[rp_raddr];
      if (nb_we) nb_mem[nb_waddr] <= nb_wdata;
      nb_rd_ff <= nb_mem[nb_raddr];
      if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
      deg_rd_ff <= deg_mem[vx_raddr];
      if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
      mark_rd_ff <= mark_mem[vx_raddr];
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      slot_rd_ff <= slot_mem[vx_raddr];
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stk_mem[stk_raddr];
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[cnt_raddr];
      if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
      ord_rd_ff <= ord_mem[ord_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         cnt_rdv_ff <= 1'b0;
         n_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_vld_ff <= cnt_vld_in;
         cnt_rdv_ff <= cnt_vld_ff[cnt_raddr];
         n_ff <= n_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;     pos_ff <= pos_in;   d_ff <= d_in;     lb_ff <= lb_in;
      i_ff <= i_in;     cnt0_ff <= cnt0_in; top_ff <= top_in; v_ff <= v_in;
      vd_ff <= vd_in;   s_ff <= s_in;       lo_ff <= lo_in;   hi_ff <= hi_in;
      err_ff <= err_in;
   end

   assign stat.u_end    = (u_ff == n_ff);
   assign stat.pos_zero = (pos_ff == 9'd0);
   assign stat.cnt_nz   = (cnt_val != 9'd0);
   assign stat.z_more   = (i_ff < cnt0_ff) && (pos_ff != 9'd0);
   assign stat.d_end    = (d_ff == VCOUNT_MAX);
   assign stat.k_end    = (lo_ff >= hi_ff);
   assign stat.v_out    = (nb_rd_ff >= {4'b0000, n_ff});
   assign stat.skip     = mark_rd_ff || (deg_rd_ff == 8'd0);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_error     = err_ff;
   assign rsp_ordered_vertex = err_ff ? 8'd0 : ord_rd_ff;

endmodule

/* hw/rtl/smallest_last_vertex_ordering.sv */
// top level of the smallest-last vertex ordering block
//
//   channel   ports                                         direction
//   request   start, busy, req_type, req_address, req_value in (busy out)
//   response  rsp_valid, rsp_ordered_vertex, rsp_read_error out
//   register  csr_wr_en, csr_wr_data                        in
//
// load and read transactions are taken one per cycle while busy is low; a read answers in the cycle after it is taken.
// a start transaction holds busy through the setup of every vertex, the degree-zero passes, each
// placement with its walk over the neighbor entries, the scan of empty degree steps and the finish;
// the sequencer walks the stack and count memories, each with one read and one write port.
// synchronous active-high reset clears the sequencer, the vertex count and the done flag.
// responses cannot be stalled.
module smallest_last_vertex_ordering (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_address,
   input  logic [12:0] req_value,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_ordered_vertex,
   output logic        rsp_read_error
);
   import slvo_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     ctrl_busy;

   slvo_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (ctrl_busy)
   );

   slvo_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .start              (start),
      .req_type           (req_type),
      .req_address        (req_address),
      .req_value          (req_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ordered_vertex (rsp_ordered_vertex),
      .rsp_read_error     (rsp_read_error)
   );

   assign busy = ctrl_busy;

`ifndef SYNTHESIS
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_type == REQ_READ))
      else $error("response without a read transaction");
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while ordering runs");
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_type == REQ_START))
      else $error("busy without a start transaction");
`endif

endmodule
